// File: design/acsa_pkg.sv
// Shared types, constants and channel tables for the ADC channel scan averager.
`timescale 1ns / 1ps
package acsa_pkg;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CHAN_W    = 3;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned VALUE_W   = 10;
  localparam int unsigned PEND_W    = 3;

  localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(4);

  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_AVG = 1'b1;

  // Result of one accepted item, handed to the output stage
  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] chan;
  } acsa_req_t;

  // Scan position to analogue channel: 0, 1, 2, 4, 5
  function automatic logic [CHAN_W-1:0] slot_channel(input logic [SLOT_W-1:0] s);
    logic [CHAN_W-1:0] c;
    case (s)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction

  // Averages go out as pot, temperature, X, Y, lever
  function automatic logic [SLOT_W-1:0] report_slot(input logic [SLOT_W-1:0] i);
    logic [SLOT_W-1:0] s;
    case (i)
      3'd0:    s = 3'd4;
      3'd1:    s = 3'd3;
      3'd2:    s = 3'd0;
      3'd3:    s = 3'd1;
      default: s = 3'd2;
    endcase
    return s;
  endfunction

endpackage

// File: design/acsa_accum.sv
// Scan position, round counter and per-channel accumulators.
`timescale 1ns / 1ps
module acsa_accum #(
  parameter int unsigned ROUNDS = 8,
  parameter int unsigned SUM_W  = 13,
  parameter int unsigned SMP_W  = 10
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       take_i,
  input  logic [SMP_W-1:0]                           sample_i,
  output acsa_pkg::acsa_req_t                        req_o,
  output logic [acsa_pkg::NUM_SLOTS-1:0][SUM_W-1:0]  sums_o
);
  import acsa_pkg::*;

  localparam int unsigned RC_W = $clog2(ROUNDS);
  localparam logic [RC_W-1:0] RC_LAST = RC_W'(ROUNDS - 1);

  logic [SLOT_W-1:0]                  slot_q, slot_d, cur, next_slot;
  logic [RC_W-1:0]                    round_q, round_d;
  logic [NUM_SLOTS-1:0][SUM_W-1:0]    sum_q, sum_d, sum_upd;
  logic                               done;

  always_comb begin
    cur = (slot_q > LAST_SLOT) ? LAST_SLOT : slot_q;
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      sum_upd[i] = sum_q[i] + ((cur == SLOT_W'(i)) ? SUM_W'(sample_i) : '0);
    end
    done      = (cur == LAST_SLOT) && (round_q == RC_LAST);
    next_slot = (cur == LAST_SLOT) ? FIRST_SLOT : cur + SLOT_W'(1);

    slot_d  = slot_q;
    round_d = round_q;
    sum_d   = sum_q;
    if (take_i) begin
      slot_d = next_slot;
      if (cur == LAST_SLOT) begin
        round_d = done ? '0 : round_q + RC_W'(1);
      end
      sum_d = done ? '0 : sum_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= LAST_SLOT;
      round_q <= '0;
      sum_q   <= '0;
    end else begin
      slot_q  <= slot_d;
      round_q <= round_d;
      sum_q   <= sum_d;
    end
  end

  assign req_o.done = done;
  assign req_o.chan = slot_channel(next_slot);
  assign sums_o     = sum_upd;

endmodule

// File: design/acsa_out.sv
// Output register with the averages snapshot and its drain sequence.
`timescale 1ns / 1ps
module acsa_out #(
  parameter int unsigned ROUNDS = 8,
  parameter int unsigned SUM_W  = 13
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       take_i,
  input  acsa_pkg::acsa_req_t                        req_i,
  input  logic [acsa_pkg::NUM_SLOTS-1:0][SUM_W-1:0]  sums_i,
  output logic                                       accept_ok_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic                                       kind_o,
  output logic [acsa_pkg::CHAN_W-1:0]                channel_o,
  output logic [acsa_pkg::VALUE_W-1:0]               value_o,
  output logic                                       last_o
);
  import acsa_pkg::*;

  // sum / ROUNDS as multiply by rounded-up reciprocal; exact for sums below 2**SUM_W
  localparam int unsigned SHIFT   = SUM_W + $clog2(ROUNDS);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(ROUNDS) - 64'd1) / 64'(ROUNDS));

  logic                               valid_q, valid_d;
  logic                               kind_q, kind_d, last_q, last_d;
  logic [CHAN_W-1:0]                  chan_q, chan_d;
  logic [VALUE_W-1:0]                 value_q, value_d;
  logic [NUM_SLOTS-1:0][SUM_W-1:0]    snap_q, snap_d;
  logic [PEND_W-1:0]                  pend_q, pend_d;
  logic [SLOT_W-1:0]                  rd_idx;
  logic [PROD_W-1:0]                  prod, quot;
  logic                               out_free;

  assign out_free    = !valid_q || out_ready_i;
  assign accept_ok_o = out_free && (pend_q == '0);

  always_comb begin
    rd_idx = SLOT_W'(NUM_SLOTS) - SLOT_W'(pend_q);
    prod   = PROD_W'(snap_q[rd_idx]) * PROD_W'(RECIP);
    quot   = prod >> SHIFT;

    valid_d = valid_q;
    kind_d  = kind_q;
    chan_d  = chan_q;
    value_d = value_q;
    last_d  = last_q;
    snap_d  = snap_q;
    pend_d  = pend_q;

    if (take_i) begin
      valid_d = 1'b1;
      kind_d  = KIND_REQ;
      chan_d  = req_i.chan;
      value_d = '0;
      last_d  = !req_i.done;
      if (req_i.done) begin
        for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
          snap_d[i] = sums_i[report_slot(SLOT_W'(i))];
        end
        pend_d = PEND_W'(NUM_SLOTS);
      end
    end else if ((pend_q != '0) && out_free) begin
      valid_d = 1'b1;
      kind_d  = KIND_AVG;
      chan_d  = slot_channel(report_slot(rd_idx));
      value_d = quot[VALUE_W-1:0];
      last_d  = (pend_q == PEND_W'(1));
      pend_d  = pend_q - PEND_W'(1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= '0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    chan_q  <= chan_d;
    value_q <= value_d;
    last_q  <= last_d;
    snap_q  <= snap_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign channel_o   = chan_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// File: design/adc_channel_scan_averager.sv
// Top level of the ADC channel scan averager.
`timescale 1ns / 1ps
// Each item is one conversion of the selected channel; the scan runs 0, 1, 2, 4, 5
// and starts at channel 5 after reset. Every item gives a request naming the next
// channel; after ROUNDS rounds it is followed by five averages (pot, temperature,
// X, Y, lever), the last one flagged. An item is taken every cycle while the output
// register is free; each completed block is followed by a drain in which the five
// averages leave the snapshot through the single reciprocal multiplier and
// no item is taken. Samples use the low SAMPLE_BITS bits (at most 10).
module adc_channel_scan_averager #(
  parameter int unsigned ROUNDS      = 8,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [acsa_pkg::SAMPLE_W-1:0]      sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               kind_o,
  output logic [acsa_pkg::CHAN_W-1:0]        channel_o,
  output logic [acsa_pkg::VALUE_W-1:0]       value_o,
  output logic                               last_o
);
  import acsa_pkg::*;

  localparam int unsigned SMP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned SUM_W = SMP_W + $clog2(ROUNDS);

  logic                               take;
  acsa_req_t                          req;
  logic [NUM_SLOTS-1:0][SUM_W-1:0]    sums;

  assign take = in_valid_i && in_ready_o;

  acsa_accum #(
    .ROUNDS (ROUNDS),
    .SUM_W  (SUM_W),
    .SMP_W  (SMP_W)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .sample_i (sample_i[SMP_W-1:0]),
    .req_o    (req),
    .sums_o   (sums)
  );

  acsa_out #(
    .ROUNDS (ROUNDS),
    .SUM_W  (SUM_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_i       (req),
    .sums_i      (sums),
    .accept_ok_o (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .channel_o   (channel_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
